[rtl/core/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define PST_ASSERT_HOLDS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

`define PST_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define PST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define PST_ASSERT_HOLDS(label, clk, rst, expr)
`define PST_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define PST_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/core/pst_pkg.sv]
package pst_pkg;

  localparam int IN_DATA_W   = 168;
  localparam int IN_USER_W   = 5;
  localparam int OUT_DATA_W  = 32;
  localparam int TS_W        = 32;
  localparam int REC_W       = TS_W + 1;
  localparam int V4_KEY_W    = 38;
  localparam int V6_KEY_W    = 136;
  localparam int V4_TOTAL_W  = 13;
  localparam int V6_TOTAL_W  = 11;
  localparam logic [V4_TOTAL_W-1:0] V4_TOTAL_MAX = '1;
  localparam logic [V6_TOTAL_W-1:0] V6_TOTAL_MAX = '1;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_FAMILY = 2'd1,
    STATUS_FULL       = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    FAM_V4 = 2'd0,
    FAM_V6 = 2'd1
  } family_t;

  typedef enum logic [1:0] {
    KIND_WITHDRAW = 2'd0,
    KIND_ANNOUNCE = 2'd1,
    KIND_RIB      = 2'd2,
    KIND_OTHER    = 2'd3
  } elem_kind_t;

  localparam logic OP_APPLY = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic              clear;
    logic              active;
    logic [TS_W-1:0]   ts;
  } tbl_req_t;

  typedef struct packed {
    status_t status;
    logic    created;
    logic    applied;
  } tbl_rsp_t;

endpackage

[rtl/core/prefix_state_table.sv]
// Prefix state table for IPv4 and IPv6 routes. Each family keeps its keys and
// records in a pair of memories with registered reads, filled from entry zero
// up, so a fill count stands in for the valid map and no clearing pass follows
// reset. An apply beat walks the used entries of its family one per cycle
// through the key memory; a hit that is not older, or an insert into a table
// that is not full, is written back in the cycle the match is seen. A clear
// beat rewrites every used record, one per cycle, in both families at once.
// An unknown family answers without starting either table. A new beat is
// taken as soon as the previous result has moved into the output register.
`include "assert_macros.svh"

module prefix_state_table #(
  parameter int V4_ENTRIES = 4096,
  parameter int V6_ENTRIES = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // address_high, address_low, prefix_length, event_time
  input  logic [pst_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // operation, elem_kind, addr_family
  input  logic [pst_pkg::IN_USER_W-1:0]      s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // status, entry_created, update_applied, v4_active_total, v6_active_total
  output logic [pst_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
  import pst_pkg::*;

  localparam int CW4 = $clog2(V4_ENTRIES + 1);
  localparam int CW6 = $clog2(V6_ENTRIES + 1);

  typedef enum logic [3:0] {
    IT_CLEAR = 4'b0001,
    IT_V4    = 4'b0010,
    IT_V6    = 4'b0100,
    IT_BAD   = 4'b1000
  } item_t;

  logic              operation;
  logic [1:0]        elem_kind;
  logic [1:0]        addr_family;
  logic [63:0]       address_high, address_low;
  logic [7:0]        prefix_length;
  logic [TS_W-1:0]   event_time;

  logic              accept, busy, wait4, wait6, res_ready;
  item_t             item;
  logic [OUT_DATA_W-1:0] res_word;

  logic              start4, start6, done4, done6;
  tbl_req_t          req;
  tbl_rsp_t          rsp4, rsp6, rsp_sel;
  logic [CW4-1:0]    count4;
  logic [CW6-1:0]    count6;
  logic [V4_KEY_W-1:0] key4;
  logic [V6_KEY_W-1:0] key6;
  logic [5:0]        len4;
  logic [7:0]        len6;
  logic [V4_TOTAL_W-1:0] total4;
  logic [V6_TOTAL_W-1:0] total6;

  assign operation     = s_axis_tuser[0];
  assign elem_kind     = s_axis_tuser[2:1];
  assign addr_family   = s_axis_tuser[4:3];
  assign address_high  = s_axis_tdata[63:0];
  assign address_low   = s_axis_tdata[127:64];
  assign prefix_length = s_axis_tdata[135:128];
  assign event_time    = s_axis_tdata[167:136];

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && !busy;

  assign len4 = (prefix_length > 8'd32) ? 6'd32 : prefix_length[5:0];
  assign len6 = (prefix_length > 8'd128) ? 8'd128 : prefix_length;
  assign key4 = {address_low[31:0], len4};
  assign key6 = {address_high, address_low, len6};

  assign req.clear  = (operation == OP_CLEAR);
  assign req.active = (elem_kind == KIND_ANNOUNCE) || (elem_kind == KIND_RIB);
  assign req.ts     = event_time;

  assign start4 = accept && (req.clear || addr_family == FAM_V4);
  assign start6 = accept && (req.clear || addr_family == FAM_V6);

  pst_table #(.ENTRIES(V4_ENTRIES), .KEY_W(V4_KEY_W)) u_v4 (
    .clk    (clk),
    .rst    (rst),
    .start  (start4),
    .req    (req),
    .key_in (key4),
    .done   (done4),
    .rsp    (rsp4),
    .count  (count4)
  );

  pst_table #(.ENTRIES(V6_ENTRIES), .KEY_W(V6_KEY_W)) u_v6 (
    .clk    (clk),
    .rst    (rst),
    .start  (start6),
    .req    (req),
    .key_in (key6),
    .done   (done6),
    .rsp    (rsp6),
    .count  (count6)
  );

  assign total4 = (32'(count4) > 32'(V4_TOTAL_MAX)) ? V4_TOTAL_MAX
                                                    : V4_TOTAL_W'(count4);
  assign total6 = (32'(count6) > 32'(V6_TOTAL_MAX)) ? V6_TOTAL_MAX
                                                    : V6_TOTAL_W'(count6);

  always_comb begin
    rsp_sel = '0;
    case (item)
      IT_CLEAR: rsp_sel = '0;
      IT_V4:    rsp_sel = rsp4;
      IT_V6:    rsp_sel = rsp6;
      IT_BAD:   rsp_sel.status = STATUS_BAD_FAMILY;
      default:  rsp_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      wait4         <= 1'b0;
      wait6         <= 1'b0;
      res_ready     <= 1'b0;
      m_axis_tvalid <= 1'b0;
      item          <= IT_BAD;
    end else begin
      if (accept) begin
        busy  <= 1'b1;
        wait4 <= start4;
        wait6 <= start6;
        if (req.clear) begin
          item <= IT_CLEAR;
        end else if (addr_family == FAM_V4) begin
          item <= IT_V4;
        end else if (addr_family == FAM_V6) begin
          item <= IT_V6;
        end else begin
          item <= IT_BAD;
        end
      end else begin
        if (done4) begin
          wait4 <= 1'b0;
        end
        if (done6) begin
          wait6 <= 1'b0;
        end
      end

      // counts are final once no engine is still waited on
      if (busy && !res_ready && !wait4 && !wait6) begin
        res_ready <= 1'b1;
        res_word  <= {{(OUT_DATA_W-4-V4_TOTAL_W-V6_TOTAL_W){1'b0}}, total6, total4,
                      rsp_sel.applied, rsp_sel.created, rsp_sel.status};
      end

      if (res_ready && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= res_word;
        res_ready     <= 1'b0;
        busy          <= 1'b0;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  `PST_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy)
  `PST_ASSERT_IMPLIES(a_res_busy, clk, rst, res_ready, busy)
  `PST_ASSERT_IMPLIES(a_done4_wait, clk, rst, done4, wait4)
  `PST_ASSERT_IMPLIES(a_done6_wait, clk, rst, done6, wait6)

endmodule

[rtl/core/pst_ram.sv]
module pst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/pst_table.sv]
`include "assert_macros.svh"

module pst_table #(
  parameter int ENTRIES = 4096,
  parameter int KEY_W   = 38
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  pst_pkg::tbl_req_t              req,
  input  logic [KEY_W-1:0]               key_in,
  output logic                           done,
  output pst_pkg::tbl_rsp_t              rsp,
  output logic [$clog2(ENTRIES+1)-1:0]   count
);
  import pst_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [AW:0] FULL_FILL = (AW+1)'(ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_CLEAR = 3'b100
  } state_t;

  state_t            state;
  logic [AW:0]       fill;
  logic [AW-1:0]     ptr;
  logic [KEY_W-1:0]  key_q;
  logic              act_q;
  logic [TS_W-1:0]   ts_q;

  logic              key_we, rec_we;
  logic [AW-1:0]     waddr, raddr;
  logic [KEY_W-1:0]  key_wdata, key_rd;
  logic [REC_W-1:0]  rec_wdata, rec_rd;

  logic              hit, last, full, newer;
  logic [CW:0]       cnt_inc;
  logic [CW-1:0]     cnt_upd;

  assign hit   = (key_rd == key_q);
  assign last  = (({1'b0, ptr} + 1'b1) == fill);
  assign full  = (fill == FULL_FILL);
  assign newer = (ts_q >= rec_rd[TS_W-1:0]);

  // overwrite of a present entry: add new activity, drop old
  always_comb begin
    cnt_inc = {1'b0, count} + {{CW{1'b0}}, act_q};
    if (rec_rd[TS_W] && cnt_inc != '0) begin
      cnt_inc = cnt_inc - 1'b1;
    end
    cnt_upd = cnt_inc[CW-1:0];
  end

  always_comb begin
    key_we    = 1'b0;
    rec_we    = 1'b0;
    waddr     = ptr;
    key_wdata = key_q;
    rec_wdata = {act_q, ts_q};
    raddr     = ptr + 1'b1;
    case (state)
      S_IDLE: begin
        raddr = '0;
        // empty table: insert straight away at entry zero
        if (start && !req.clear && fill == '0) begin
          key_we    = 1'b1;
          rec_we    = 1'b1;
          waddr     = '0;
          key_wdata = key_in;
          rec_wdata = {req.active, req.ts};
        end
      end
      S_SCAN: begin
        if (hit) begin
          rec_we = newer;
        end else if (last && !full) begin
          key_we = 1'b1;
          rec_we = 1'b1;
          waddr  = fill[AW-1:0];
        end
      end
      S_CLEAR: begin
        rec_we    = 1'b1;
        rec_wdata = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            key_q <= key_in;
            act_q <= req.active;
            ts_q  <= req.ts;
            ptr   <= '0;
            rsp   <= '0;
            if (req.clear) begin
              count <= '0;
              if (fill == '0) begin
                done <= 1'b1;
              end else begin
                state <= S_CLEAR;
              end
            end else if (fill == '0) begin
              fill        <= (AW+1)'(1);
              count       <= count + {{(CW-1){1'b0}}, req.active};
              rsp.created <= 1'b1;
              rsp.applied <= 1'b1;
              done        <= 1'b1;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            if (newer) begin
              count       <= cnt_upd;
              rsp.applied <= 1'b1;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (last) begin
            if (full) begin
              rsp.status <= STATUS_FULL;
            end else begin
              fill        <= fill + 1'b1;
              count       <= count + {{(CW-1){1'b0}}, act_q};
              rsp.created <= 1'b1;
              rsp.applied <= 1'b1;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_CLEAR: begin
          if (last) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  pst_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (waddr),
    .wdata (key_wdata),
    .raddr (raddr),
    .rdata (key_rd)
  );

  pst_ram #(.WIDTH(REC_W), .DEPTH(ENTRIES)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (waddr),
    .wdata (rec_wdata),
    .raddr (raddr),
    .rdata (rec_rd)
  );

  `PST_ASSERT_HOLDS(a_fill_bound, clk, rst, fill <= FULL_FILL)
  `PST_ASSERT_HOLDS(a_count_bound, clk, rst, {1'b0, count} <= (CW+1)'(fill))
  `PST_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  `PST_ASSERT_IMPLIES(a_insert_free, clk, rst, key_we && state == S_SCAN, !full)

endmodule

[tb/tb_prefix_state_table.sv]
`timescale 1ns / 100ps

module tb_prefix_state_table;
  import pst_pkg::*;

  localparam int V4_N = 4096;
  localparam int V6_N = 1024;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [10:0] v6_total;
    logic [12:0] v4_total;
    logic        applied;
    logic        created;
    logic [1:0]  status;
  } route_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [IN_USER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  prefix_state_table #(.V4_ENTRIES(V4_N), .V6_ENTRIES(V6_N)) i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // shadow copy of both prefix tables, filled from entry zero up
  logic [37:0]  v4_keys [V4_N];
  logic [32:0]  v4_recs [V4_N];
  int           v4_fill;
  logic [135:0] v6_keys [V6_N];
  logic [32:0]  v6_recs [V6_N];
  int           v6_fill;
  int           v4_active, v6_active;

  route_result_t expected_results[$];
  int errors = 0;
  int idle_cycles = 0;
  int sent = 0, received = 0, n_created = 0, n_full = 0, n_stale = 0;
  bit wait_fill = 1'b0;

  function automatic route_result_t predict_route(logic op, elem_kind_t kind, logic [1:0] fam,
                                                  logic [63:0] hi, logic [63:0] lo,
                                                  logic [7:0] len, logic [31:0] ts);
    route_result_t r;
    logic act;
    int hit;
    logic [135:0] key;
    r = '0;
    act = (kind == KIND_ANNOUNCE) || (kind == KIND_RIB);
    hit = -1;
    if (op == OP_CLEAR) begin
      for (int i = 0; i < v4_fill; i++) v4_recs[i] = '0;
      for (int i = 0; i < v6_fill; i++) v6_recs[i] = '0;
      v4_active = 0;
      v6_active = 0;
    end else if (fam == FAM_V4 || fam == FAM_V6) begin
      if (fam == FAM_V4) key = {98'd0, lo[31:0], (len > 32) ? 6'd32 : len[5:0]};
      else key = {hi, lo, (len > 128) ? 8'd128 : len};
      if (fam == FAM_V4) begin
        for (int i = 0; i < v4_fill; i++) if (v4_keys[i] == key[37:0]) begin hit = i; break; end
      end else begin
        for (int i = 0; i < v6_fill; i++) if (v6_keys[i] == key) begin hit = i; break; end
      end
      if (hit >= 0) begin
        logic [32:0] old;
        old = (fam == FAM_V4) ? v4_recs[hit] : v6_recs[hit];
        if (ts >= old[31:0]) begin
          if (fam == FAM_V4) begin
            v4_recs[hit] = {act, ts};
            v4_active += act;
            if (old[32] && v4_active > 0) v4_active--;
          end else begin
            v6_recs[hit] = {act, ts};
            v6_active += act;
            if (old[32] && v6_active > 0) v6_active--;
          end
          r.applied = 1'b1;
        end else n_stale++;
      end else if (fam == FAM_V4 && v4_fill < V4_N) begin
        v4_keys[v4_fill] = key[37:0];
        v4_recs[v4_fill] = {act, ts};
        v4_fill++;
        v4_active += act;
        r.created = 1'b1;
        r.applied = 1'b1;
      end else if (fam == FAM_V6 && v6_fill < V6_N) begin
        v6_keys[v6_fill] = key;
        v6_recs[v6_fill] = {act, ts};
        v6_fill++;
        v6_active += act;
        r.created = 1'b1;
        r.applied = 1'b1;
      end else begin
        r.status = STATUS_FULL;
        n_full++;
      end
    end else begin
      r.status = STATUS_BAD_FAMILY;
    end
    r.v4_total = (v4_active > 8191) ? 13'h1fff : v4_active[12:0];
    r.v6_total = (v6_active > 2047) ? 11'h7ff : v6_active[10:0];
    if (r.created) n_created++;
    return r;
  endfunction

  task automatic send_route(logic op, elem_kind_t kind, logic [1:0] fam, logic [63:0] hi,
                            logic [63:0] lo, logic [7:0] len, logic [31:0] ts);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {ts, len, lo, hi};
    s_axis_tuser <= {fam, kind, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_results.push_back(predict_route(op, kind, fam, hi, lo, len, ts));
    sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic elem_kind_t rand_kind();
    return elem_kind_t'($urandom_range(0, 3));
  endfunction

  task automatic test_directed();
    send_route(OP_APPLY, KIND_ANNOUNCE, FAM_V4, '1, 64'hffff_ffff_ffff_ffff, 8'd255, '1);
    send_route(OP_APPLY, KIND_ANNOUNCE, FAM_V4, '0, 64'h0000_0000_ffff_ffff, 8'd32, 32'd5);
    send_route(OP_APPLY, KIND_WITHDRAW, FAM_V4, '0, 64'h0000_0000_ffff_ffff, 8'd32, 32'd4);
    send_route(OP_APPLY, KIND_RIB, FAM_V4, '0, 64'd0, 8'd0, 32'd0);
    send_route(OP_APPLY, KIND_OTHER, FAM_V4, '0, 64'd0, 8'd0, 32'd0);
    send_route(OP_APPLY, KIND_ANNOUNCE, FAM_V6, '1, '1, 8'd255, 32'd10);
    send_route(OP_APPLY, KIND_RIB, FAM_V6, '1, '1, 8'd128, 32'd10);
    send_route(OP_APPLY, KIND_WITHDRAW, FAM_V6, '1, '1, 8'd128, 32'd9);
    send_route(OP_APPLY, KIND_WITHDRAW, FAM_V6, '1, '1, 8'd128, 32'd11);
    send_route(OP_APPLY, KIND_ANNOUNCE, FAM_V6, '0, '0, 8'd0, '1);
    send_route(OP_APPLY, KIND_ANNOUNCE, 2'd2, '1, '1, 8'd8, 32'd1);
    send_route(OP_APPLY, KIND_ANNOUNCE, 2'd3, '0, '0, 8'd8, 32'd1);
    send_route(OP_CLEAR, KIND_OTHER, 2'd3, '1, '1, '1, '1);
    send_route(OP_APPLY, KIND_ANNOUNCE, FAM_V4, '0, 64'd0, 8'd0, 32'd0);
    send_route(OP_APPLY, KIND_ANNOUNCE, FAM_V6, '0, '0, 8'd0, 32'd0);
    send_route(OP_CLEAR, KIND_WITHDRAW, FAM_V4, '0, '0, '0, '0);
    drain_results();
  endtask

  // small key pools so hits, stale updates and re-announcements are frequent
  task automatic test_random_routes(int count);
    logic [63:0] hi, lo;
    logic [31:0] ts;
    logic [1:0] fam;
    logic [7:0] len;
    for (int n = 0; n < count; n++) begin
      hi = {$urandom(), $urandom()};
      lo = {$urandom(), $urandom()};
      len = 8'($urandom_range(0, 255));
      ts = $urandom();
      case ($urandom_range(0, 9))
        0: fam = 2'($urandom_range(2, 3));
        1, 2, 3, 4, 5: fam = FAM_V4;
        default: fam = FAM_V6;
      endcase
      if ($urandom_range(0, 3) != 0) begin
        hi = {62'd0, hi[1:0]};
        lo = {lo[63:62], 59'd0, lo[2:0]};
        len = (fam == FAM_V4) ? 8'($urandom_range(30, 34)) : 8'($urandom_range(126, 130));
        ts = $urandom_range(0, 40) + (($urandom_range(0, 7) == 0) ? 32'hffff_ffd0 : 32'd0);
      end
      if (n == count / 2) drain_results();
      send_route(($urandom_range(0, 79) == 0) ? OP_CLEAR : OP_APPLY, rand_kind(), fam,
                 hi, lo, len, ts);
    end
    drain_results();
  endtask

  // fill the v6 table up to the table-full case
  task automatic test_table_full();
    for (int n = 0; n < V6_N + 4; n++)
      send_route(OP_APPLY, rand_kind(), FAM_V6, 64'hdead_0000 + 64'(n), 64'(n), 8'd64,
                 $urandom());
    send_route(OP_CLEAR, KIND_OTHER, FAM_V6, '0, '0, '0, '0);
    drain_results();
  endtask

  always @(posedge clk) begin
    route_result_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 15) == 0) ? 1'b0 :
                       ($urandom_range(0, 1) == 0) || m_axis_tready;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[27:0];
        received++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected beat, actual %h", $time, got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.created !== want.created ||
              got.applied !== want.applied || got.v4_total !== want.v4_total ||
              got.v6_total !== want.v6_total || m_axis_tdata[31:28] !== 4'd0) begin
            $display("%0t: mismatch, expected %h actual %h", $time, want, m_axis_tdata);
            errors++;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    v4_fill = 0; v6_fill = 0; v4_active = 0; v6_active = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_routes(100);
    test_table_full();
    repeat (50) @(posedge clk);
    $display("sent %0d beats, checked %0d results: %0d inserts, %0d stale, %0d table full",
             sent, received, n_created, n_stale, n_full);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
